// ----- hdl/sparse_markowitz_pivot_select_top_defines.svh -----
// Assertion macros shared by the pivot select RTL.
// Used by sparse_markowitz_pivot_select_top; needs nothing else.
`ifndef SPARSE_MARKOWITZ_PIVOT_SELECT_TOP_DEFINES_SVH
`define SPARSE_MARKOWITZ_PIVOT_SELECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SMPS_ASSERT_IMP(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SMPS_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/smps_pkg.sv -----
// Shared types and helpers for the pivot select block.
// Used by smps_crit_pipe and sparse_markowitz_pivot_select_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smps_pkg;

  localparam int ROW_W = 10;
  localparam int CNT_W = 11;
  localparam int DBL_W = 64;

  localparam logic [DBL_W-1:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_INF  = 64'h7FF0_0000_0000_0000;

  // Sideband that travels with an item through the arithmetic pipeline.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic             has;
    logic             piv;
  } side_t;

  function automatic logic f64_is_nan(input logic [DBL_W-1:0] x);
    return (&x[62:52]) && (|x[51:0]);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/smps_crit_pipe.sv -----
// Pipelined |a*b| and |a*b| * 2^-cnt in IEEE double, round to nearest even.
// Depends on smps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smps_crit_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire smps_pkg::side_t             src_side,
  input  wire logic [smps_pkg::DBL_W-1:0]  op_a,
  input  wire logic [smps_pkg::DBL_W-1:0]  op_b,
  input  wire logic [smps_pkg::CNT_W-1:0]  op_cnt,
  output smps_pkg::side_t                  res_side,
  output logic [smps_pkg::DBL_W-1:0]       mag,
  output logic [smps_pkg::DBL_W-1:0]       crit
);

  function automatic logic [5:0] lzc53(input logic [52:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd53;
    hit = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(52 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [52:0] mant_of(input logic [63:0] x);
    if (x[62:52] != 11'd0) begin
      return {1'b1, x[51:0]};
    end
    return {1'b0, x[51:0]} << lzc53({1'b0, x[51:0]});
  endfunction

  function automatic logic signed [12:0] exp_of(input logic [63:0] x);
    if (x[62:52] != 11'd0) begin
      return $signed({2'b00, x[62:52]}) - 13'sd1075;
    end
    return -13'sd1074 - $signed({7'd0, lzc53({1'b0, x[51:0]})});
  endfunction

  // Stage 1: captured operands.
  smps_pkg::side_t              side1;
  logic [63:0]                  a1, b1;
  logic [smps_pkg::CNT_W-1:0]   cnt1;
  // Stage 2: normalized significands and exponents.
  smps_pkg::side_t              side2;
  logic [52:0]                  ma2, mb2;
  logic signed [12:0]           ea2, eb2;
  logic                         nan2, inf2, zero2;
  logic [smps_pkg::CNT_W-1:0]   cnt2;
  // Stage 3: partial products.
  smps_pkg::side_t              side3;
  logic [51:0]                  pp_hh;
  logic [52:0]                  pp_hl, pp_lh;
  logic [53:0]                  pp_ll;
  logic signed [12:0]           esum3;
  logic                         nan3, inf3, zero3;
  logic [smps_pkg::CNT_W-1:0]   cnt3;
  // Stage 4: full product.
  smps_pkg::side_t              side4;
  logic [105:0]                 prod4;
  logic signed [12:0]           esum4;
  logic                         nan4, inf4, zero4;
  logic [smps_pkg::CNT_W-1:0]   cnt4;
  // Stage 5: rounded magnitude.
  smps_pkg::side_t              side5;
  logic [63:0]                  mag5;
  logic [smps_pkg::CNT_W-1:0]   cnt5;
  // Stage 6: criterion.
  smps_pkg::side_t              side6;
  logic [63:0]                  mag6, crit6;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic nan_next, inf_next, zero_next;

  always_comb begin
    a_nan  = smps_pkg::f64_is_nan(a1);
    b_nan  = smps_pkg::f64_is_nan(b1);
    a_inf  = (&a1[62:52]) && (a1[51:0] == 52'd0);
    b_inf  = (&b1[62:52]) && (b1[51:0] == 52'd0);
    a_zero = (a1[62:0] == 63'd0);
    b_zero = (b1[62:0] == 63'd0);
    nan_next  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
    inf_next  = (a_inf || b_inf) && !nan_next;
    zero_next = (a_zero || b_zero) && !nan_next && !inf_next;
  end

  // Product normalization and rounding.
  logic               p_top;
  logic signed [12:0] p_exp;
  logic signed [12:0] p_dsh;
  logic [5:0]         p_dcl;
  logic [105:0]       p_sig, p_shf, p_msk;
  logic [52:0]        p_mant;
  logic               p_grd, p_stk;
  logic [63:0]        mag_next;

  always_comb begin
    p_top  = prod4[105];
    p_exp  = esum4 + 13'sd1127 + $signed({12'd0, p_top});
    p_sig  = p_top ? prod4 : {prod4[104:0], 1'b0};
    p_dsh  = (p_exp <= 13'sd0) ? (13'sd1 - p_exp) : 13'sd0;
    p_dcl  = (p_dsh > 13'sd60) ? 6'd60 : p_dsh[5:0];
    p_shf  = p_sig >> p_dcl;
    p_msk  = (106'd1 << p_dcl) - 106'd1;
    p_mant = p_shf[105:53];
    p_grd  = p_shf[52];
    p_stk  = (|p_shf[51:0]) || (|(p_sig & p_msk));
    if (nan4) begin
      mag_next = smps_pkg::DBL_QNAN;
    end else if (inf4) begin
      mag_next = smps_pkg::DBL_INF;
    end else if (zero4) begin
      mag_next = 64'd0;
    end else if (p_exp >= 13'sd2047) begin
      mag_next = smps_pkg::DBL_INF;
    end else begin
      // A carry out of the fraction moves into the exponent field on its own.
      mag_next = {1'b0, (p_exp <= 13'sd0) ? 11'd0 : p_exp[10:0], p_mant[51:0]}
               + {63'd0, p_grd && (p_stk || p_mant[0])};
    end
  end

  // Scaling by 2^-cnt with rounding into the subnormal range.
  logic               s_nan, s_inf, s_big;
  logic [10:0]        s_em;
  logic signed [12:0] s_new, s_sh;
  logic [5:0]         s_shc;
  logic [63:0]        s_x, s_shf, s_msk;
  logic [52:0]        s_mant;
  logic               s_grd, s_stk;
  logic [63:0]        crit_next;

  always_comb begin
    s_nan  = smps_pkg::f64_is_nan(mag5);
    s_inf  = (&mag5[62:52]) && (mag5[51:0] == 52'd0);
    s_big  = cnt5[10];
    s_em   = mag5[62:52];
    s_new  = ((s_em != 11'd0) ? $signed({2'b00, s_em}) : 13'sd1)
           - $signed({2'b00, cnt5});
    s_sh   = 13'sd1 - s_new;
    s_shc  = (s_sh > 13'sd63) ? 6'd63 : s_sh[5:0];
    s_x    = {(s_em != 11'd0), mag5[51:0], 11'd0};
    s_shf  = s_x >> s_shc;
    s_msk  = (64'd1 << s_shc) - 64'd1;
    s_mant = s_shf[63:11];
    s_grd  = s_shf[10];
    s_stk  = (|s_shf[9:0]) || (|(s_x & s_msk));
    if (s_nan || (s_inf && s_big)) begin
      crit_next = smps_pkg::DBL_QNAN;
    end else if (s_inf) begin
      crit_next = smps_pkg::DBL_INF;
    end else if (s_big) begin
      crit_next = 64'd0;
    end else if ((s_em != 11'd0) && (s_new >= 13'sd1)) begin
      crit_next = {1'b0, s_new[10:0], mag5[51:0]};
    end else begin
      crit_next = {12'd0, s_mant[51:0]} + {63'd0, s_grd && (s_stk || s_mant[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
      side2 <= '0;
      side3 <= '0;
      side4 <= '0;
      side5 <= '0;
      side6 <= '0;
    end else if (adv) begin
      side1 <= src_side;
      side2 <= side1;
      side3 <= side2;
      side4 <= side3;
      side5 <= side4;
      side6 <= side5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= op_a;
      b1    <= op_b;
      cnt1  <= op_cnt;
      ma2   <= mant_of(a1);
      mb2   <= mant_of(b1);
      ea2   <= exp_of(a1);
      eb2   <= exp_of(b1);
      nan2  <= nan_next;
      inf2  <= inf_next;
      zero2 <= zero_next;
      cnt2  <= cnt1;
      pp_hh <= ma2[52:27] * mb2[52:27];
      pp_hl <= ma2[52:27] * mb2[26:0];
      pp_lh <= ma2[26:0] * mb2[52:27];
      pp_ll <= ma2[26:0] * mb2[26:0];
      esum3 <= ea2 + eb2;
      nan3  <= nan2;
      inf3  <= inf2;
      zero3 <= zero2;
      cnt3  <= cnt2;
      prod4 <= {pp_hh, 54'd0} + {26'd0, pp_hl, 27'd0} + {26'd0, pp_lh, 27'd0}
             + {52'd0, pp_ll};
      esum4 <= esum3;
      nan4  <= nan3;
      inf4  <= inf3;
      zero4 <= zero3;
      cnt4  <= cnt3;
      mag5  <= mag_next;
      cnt5  <= cnt4;
      mag6  <= mag5;
      crit6 <= crit_next;
    end
  end

  assign res_side = side6;
  assign mag      = mag6;
  assign crit     = crit6;

endmodule

`default_nettype wire

// ----- hdl/sparse_markowitz_pivot_select_top.sv -----
// Markowitz scaled partial pivot selection for one pivot column, streaming.
// Depends on smps_pkg, smps_crit_pipe and sparse_markowitz_pivot_select_top_defines.svh.
//
// Rows of one pivot column arrive bottom row first, one beat per row, and the
// pivot row beat ends the column. The block takes one row beat every clock
// while in_stall is low. Each beat passes six pipeline registers in the
// floating-point path (operand capture, normalize, partial products, product
// sum, round |value*scale|, scale by 2^-count). The compare-and-update against
// the current best row works on the sixth register, and its zero, one or two
// result beats are written into a four-entry result queue at the end of the
// same cycle. Results leave that queue one beat a cycle while out_stall is
// low. Input stall rises only while the queue holds more than two results, so
// an output that is stalled backs the input up after a few beats, and a running
// output never slows the input. The tolerance register is written through its
// own valid/ready port, which is always ready; write it only while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_markowitz_pivot_select_top_defines.svh"

module sparse_markowitz_pivot_select_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write port.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [smps_pkg::DBL_W-1:0]  cfg_data,
  // Row beats.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [smps_pkg::ROW_W-1:0]  row_index,
  input  wire logic                        has_entry,
  input  wire logic [smps_pkg::DBL_W-1:0]  entry_value,
  input  wire logic [smps_pkg::DBL_W-1:0]  row_scale,
  input  wire logic [smps_pkg::CNT_W-1:0]  row_entries,
  input  wire logic                        is_pivot_row,
  // Result beats.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             kind,
  output logic [smps_pkg::ROW_W-1:0]       row_out,
  output logic                             singular,
  output logic                             last
);

  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_QW    = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic                       kind;
    logic [smps_pkg::ROW_W-1:0] row;
    logic                       sing;
    logic                       last;
  } res_t;

  // Tolerance register; the port never pushes back.
  logic [smps_pkg::DBL_W-1:0] singular_tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      singular_tolerance <= cfg_data;
    end
  end

  // The whole pipeline moves together and holds only when the result queue
  // could not absorb two more results.
  logic                 adv;
  logic [CNT_QW-1:0]    res_count;
  smps_pkg::side_t      src_side;
  smps_pkg::side_t      side6;
  logic [smps_pkg::DBL_W-1:0] mag6, crit6;

  assign adv      = (res_count <= CNT_QW'(RES_DEPTH - 2));
  assign in_stall = !adv;

  always_comb begin
    src_side.valid = in_valid;
    src_side.row   = row_index;
    src_side.has   = has_entry;
    src_side.piv   = is_pivot_row;
  end

  smps_crit_pipe u_crit (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .src_side (src_side),
    .op_a     (entry_value),
    .op_b     (row_scale),
    .op_cnt   (row_entries),
    .res_side (side6),
    .mag      (mag6),
    .crit     (crit6)
  );

  // Column state: the best row so far.
  logic                       found_first;
  logic [smps_pkg::DBL_W-1:0] best_criterion;
  logic [smps_pkg::DBL_W-1:0] best_magnitude;
  logic [smps_pkg::ROW_W-1:0] best_row;

  logic                       fire;
  logic                       beats_best;
  logic                       take_new;
  logic                       lst_v, vrd_v;
  res_t                       lst, vrd;
  res_t                       push_a, push_b;
  logic [1:0]                 push_n;
  logic                       found_first_next;
  logic [smps_pkg::DBL_W-1:0] best_criterion_next;
  logic [smps_pkg::DBL_W-1:0] best_magnitude_next;
  logic [smps_pkg::ROW_W-1:0] best_row_next;
  logic                       sing_now;

  always_comb begin
    fire = adv && side6.valid;
    // Both criteria are non-negative, so their bit patterns order like values;
    // NaN on either side never compares greater.
    beats_best = !smps_pkg::f64_is_nan(crit6) && !smps_pkg::f64_is_nan(best_criterion)
              && (crit6[62:0] > best_criterion[62:0]);
    take_new   = side6.has && (!found_first || beats_best);

    found_first_next    = found_first || side6.has;
    best_criterion_next = take_new ? crit6 : best_criterion;
    best_magnitude_next = take_new ? mag6 : best_magnitude;
    best_row_next       = take_new ? side6.row : best_row;

    // A row that loses is listed as is, except the pivot row, whose contents
    // go to the chosen row after the swap. A row that wins lists the old best.
    lst_v    = side6.has && found_first;
    lst.kind = 1'b0;
    lst.row  = (beats_best || side6.piv) ? best_row : side6.row;
    lst.sing = 1'b0;
    lst.last = 1'b0;

    sing_now = !smps_pkg::f64_is_nan(best_magnitude_next)
            && !smps_pkg::f64_is_nan(singular_tolerance)
            && !singular_tolerance[63]
            && (best_magnitude_next[62:0] < singular_tolerance[62:0]);
    vrd_v    = side6.piv;
    vrd.kind = 1'b1;
    vrd.row  = found_first_next ? best_row_next : side6.row;
    vrd.sing = found_first_next ? sing_now : 1'b1;
    vrd.last = 1'b1;

    push_a = lst_v ? lst : vrd;
    push_b = vrd;
    push_n = fire ? ({1'b0, lst_v} + {1'b0, vrd_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_first    <= 1'b0;
      best_criterion <= '0;
      best_magnitude <= '0;
      best_row       <= '0;
    end else if (fire) begin
      if (side6.piv) begin
        found_first    <= 1'b0;
        best_criterion <= '0;
        best_magnitude <= '0;
        best_row       <= '0;
      end else begin
        found_first    <= found_first_next;
        best_criterion <= best_criterion_next;
        best_magnitude <= best_magnitude_next;
        best_row       <= best_row_next;
      end
    end
  end

  // Result queue: up to two writes and one read a cycle.
  res_t             res_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             pop;
  res_t             head;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (res_count != '0);
  assign head      = res_q[rd_ptr];
  assign kind      = head.kind;
  assign row_out   = head.row;
  assign singular  = head.sing;
  assign last      = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      wr_ptr    <= wr_ptr + PTR_W'(push_n);
      rd_ptr    <= rd_ptr + PTR_W'(pop);
      res_count <= res_count + CNT_QW'(push_n) - CNT_QW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      res_q[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      res_q[wr_ptr + PTR_W'(1)] <= push_b;
    end
  end

  `SMPS_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, res_count <= CNT_QW'(RES_DEPTH))
  `SMPS_ASSERT_IMP(a_stall_has_results, clk, rst, in_stall, out_valid)
  `SMPS_ASSERT_IMP(a_double_push_ends_column, clk, rst, push_n == 2'd2, side6.piv && push_b.last)
  `SMPS_ASSERT_NEXT(a_verdict_clears, clk, rst, fire && side6.piv, !found_first)

endmodule

`default_nettype wire

// ----- dv/sparse_markowitz_pivot_select_top_tb.sv -----
// Self-checking testbench for the streaming Markowitz pivot select block.
// Depends on smps_pkg and sparse_markowitz_pivot_select_top; reads no files.
`timescale 1ns / 1ps

module sparse_markowitz_pivot_select_top_tb;

  localparam logic KIND_LIST    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   SETTLE       = 40;
  localparam int   HOLD_LEN     = 300;
  localparam int   HOLD_AT_ROW  = 60;

  // One row beat of a pivot column.
  typedef struct {
    logic [smps_pkg::ROW_W-1:0] row;
    logic                       has;
    logic [smps_pkg::DBL_W-1:0] value;
    logic [smps_pkg::DBL_W-1:0] scale;
    logic [smps_pkg::CNT_W-1:0] cnt;
    logic                       piv;
  } row_beat_t;

  // One predicted result beat.
  typedef struct {
    logic                       kind;
    logic [smps_pkg::ROW_W-1:0] row;
    logic                       sing;
    logic                       last;
  } pivot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [smps_pkg::DBL_W-1:0] cfg_data = '0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [smps_pkg::ROW_W-1:0] row_index = '0;
  logic                       has_entry = 1'b0;
  logic [smps_pkg::DBL_W-1:0] entry_value = '0;
  logic [smps_pkg::DBL_W-1:0] row_scale = '0;
  logic [smps_pkg::CNT_W-1:0] row_entries = '0;
  logic                       is_pivot_row = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       kind;
  logic [smps_pkg::ROW_W-1:0] row_out;
  logic                       singular;
  logic                       last;

  sparse_markowitz_pivot_select_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_index(row_index), .has_entry(has_entry), .entry_value(entry_value),
    .row_scale(row_scale), .row_entries(row_entries), .is_pivot_row(is_pivot_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .row_out(row_out), .singular(singular), .last(last)
  );

  // Rows waiting to be offered, and result beats the block still owes us.
  row_beat_t     pending_rows[$];
  pivot_result_t owed_results[$];

  // Shadow copy of the pivot search state and the tolerance register.
  logic [smps_pkg::DBL_W-1:0] tol_bits = '0;
  logic                       have_best = 1'b0;
  real                        best_crit = 0.0;
  real                        best_mag  = 0.0;
  logic [smps_pkg::ROW_W-1:0] best_row  = '0;

  int  send_idle_pct = 11;
  int  recv_idle_pct = 53;
  int  rows_taken = 0;
  int  mismatches = 0;
  int  cycles = 0;
  logic row_taken = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sparse_markowitz_pivot_select_top_tb: FAIL");
      $finish;
    end
  end

  function automatic pivot_result_t mk_result(logic k, logic [smps_pkg::ROW_W-1:0] r,
                                              logic s);
    pivot_result_t res;
    res.kind = k;
    res.row  = r;
    res.sing = s;
    res.last = k;
    return res;
  endfunction

  task automatic owe_result(input pivot_result_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  task automatic queue_row(input row_beat_t b);
    pending_rows.insert(pending_rows.size(), b);
  endtask

  // Advance the shadow search by one accepted row beat and queue what it
  // should produce. All arithmetic is plain IEEE double, as in the block.
  task automatic predict_pivot(input row_beat_t b);
    real mag;
    real crit;
    real pow2;
    if (b.has) begin
      mag = $bitstoreal(b.value) * $bitstoreal(b.scale);
      if (mag < 0.0) mag = -mag;
      if (b.cnt >= 1024) pow2 = $bitstoreal(smps_pkg::DBL_INF);
      else pow2 = $bitstoreal({1'b0, 11'(b.cnt + 11'd1023), 52'b0});
      crit = mag / pow2;
      if (!have_best) begin
        have_best = 1'b1;
        best_mag  = mag;
        best_crit = crit;
        best_row  = b.row;
      end else if (crit > best_crit) begin
        owe_result(mk_result(KIND_LIST, best_row, 1'b0));
        best_mag  = mag;
        best_crit = crit;
        best_row  = b.row;
      end else begin
        // A losing pivot row is listed where its contents land after the swap.
        owe_result(mk_result(KIND_LIST, b.piv ? best_row : b.row, 1'b0));
      end
    end
    if (b.piv) begin
      if (!have_best)
        owe_result(mk_result(KIND_VERDICT, b.row, 1'b1));
      else
        owe_result(mk_result(KIND_VERDICT, best_row, best_mag < $bitstoreal(tol_bits)));
      have_best = 1'b0;
      best_crit = 0.0;
      best_mag  = 0.0;
      best_row  = '0;
    end
  endtask

  // Input side monitor plus output checker, both sampled on the rising edge.
  always @(posedge clk) begin
    pivot_result_t want;
    if (rst) begin
      row_taken <= 1'b0;
    end else begin
      row_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_pivot('{row_index, has_entry, entry_value, row_scale, row_entries,
                        is_pivot_row});
        rows_taken <= rows_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: kind=%0d row_out=%0d", kind, row_out);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
          end
          if (row_out !== want.row) begin
            $error("row_out: expected %0d, got %0d", want.row, row_out);
            mismatches++;
          end
          if (singular !== want.sing) begin
            $error("singular: expected %0d, got %0d", want.sing, singular);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
          end
        end
      end
    end
  end

  // Row driver. A beat stays on the bus until it is taken; only then may the
  // driver go idle or load the next pending row.
  always @(negedge clk) begin
    logic      offer;
    row_beat_t nxt;
    offer = in_valid;
    if (in_valid && row_taken) offer = 1'b0;
    if (!rst && !offer && pending_rows.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nxt = pending_rows.pop_front();
      offer = 1'b1;
      row_index    <= nxt.row;
      has_entry    <= nxt.has;
      entry_value  <= nxt.value;
      row_scale    <= nxt.scale;
      row_entries  <= nxt.cnt;
      is_pivot_row <= nxt.piv;
    end
    in_valid <= offer;
  end

  // Result receiver. Once, after a few dozen rows are in, it holds off for a
  // long stretch so the result queue fills and the input stall kicks in.
  int  hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && rows_taken >= HOLD_AT_ROW) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Mostly values near 1.0 so the tolerance matters, plus zeros, infinities,
  // NaNs, subnormals and raw random patterns.
  function automatic logic [smps_pkg::DBL_W-1:0] pick_double();
    logic [smps_pkg::DBL_W-1:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(11))
      0: d = {d[63], 63'b0};
      1: d = {d[63], 11'h7FF, 52'b0};
      2: d = {d[63], 11'h7FF, d[51:1], 1'b1};
      3: d = {d[63], 11'b0, d[51:0]};
      4: ;
      default: d = {d[63], 11'($urandom_range(1033, 1013)), d[51:0]};
    endcase
    return d;
  endfunction

  function automatic logic [smps_pkg::CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0: return 11'($urandom_range(2047, 1020));
      1: return 11'($urandom_range(2047));
      default: return 11'($urandom_range(12));
    endcase
  endfunction

  function automatic row_beat_t mk_row(logic [smps_pkg::ROW_W-1:0] r, logic h,
                                       logic [smps_pkg::DBL_W-1:0] v,
                                       logic [smps_pkg::DBL_W-1:0] s,
                                       logic [smps_pkg::CNT_W-1:0] c, logic p);
    row_beat_t b;
    b.row = r; b.has = h; b.value = v; b.scale = s; b.cnt = c; b.piv = p;
    return b;
  endfunction

  // Queue one column of random rows, descending to the pivot row.
  task automatic queue_column(inout int queued);
    int n;
    int r;
    n = $urandom_range(7, 1);
    r = $urandom_range(1023, n - 1);
    for (int i = n - 1; i >= 0; i--) begin
      queue_row(mk_row(10'(r), $urandom_range(99) < 70, pick_double(),
                       pick_double(), pick_count(), i == 0));
      r = (r > 0) ? r - $urandom_range(1, 1) - (($urandom_range(3) == 0) ? 1 : 0) : 0;
      if (r < 0) r = 0;
      queued++;
    end
    // Occasionally a stray row order, which the block takes as given.
    if ($urandom_range(19) == 0) begin
      queue_row(mk_row(10'($urandom), 1'b1, pick_double(), pick_double(),
                       pick_count(), 1'b0));
      queue_row(mk_row(10'($urandom), 1'($urandom_range(1)), pick_double(),
                       pick_double(), pick_count(), 1'b1));
      queued += 2;
    end
  endtask

  // Let everything queued drain, then give items that produce nothing time
  // to clear the pipeline.
  task automatic drain_block();
    while (pending_rows.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [smps_pkg::DBL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tol_bits = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_rows, input int s_pct, input int r_pct);
    int queued;
    queued = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (queued < n_rows) queue_column(queued);
    drain_block();
  endtask

  localparam logic [smps_pkg::DBL_W-1:0] ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [smps_pkg::DBL_W-1:0] TWO   = 64'h4000_0000_0000_0000;
  localparam logic [smps_pkg::DBL_W-1:0] HALF  = 64'h3FE0_0000_0000_0000;
  localparam logic [smps_pkg::DBL_W-1:0] NEG3  = 64'hC008_0000_0000_0000;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_tolerance(64'h0);
    // Column with no entry at all: singular, reported at the pivot row.
    queue_row(mk_row(10'd1023, 1'b0, '1, '1, 11'h7FF, 1'b0));
    queue_row(mk_row(10'd0, 1'b0, '0, '0, 11'd0, 1'b1));
    // Pivot row has an entry but loses: its list entry names the winner.
    queue_row(mk_row(10'd9, 1'b1, NEG3, TWO, 11'd1, 1'b0));
    queue_row(mk_row(10'd8, 1'b1, ONE, ONE, 11'd0, 1'b0));
    queue_row(mk_row(10'd7, 1'b1, HALF, ONE, 11'd2, 1'b1));
    // Tie keeps the row that came first; a strictly better later row takes over.
    queue_row(mk_row(10'd5, 1'b1, TWO, ONE, 11'd1, 1'b0));
    queue_row(mk_row(10'd4, 1'b1, ONE, ONE, 11'd0, 1'b0));
    queue_row(mk_row(10'd3, 1'b1, NEG3, ONE, 11'd0, 1'b1));
    // Huge row counts: divide by infinity, and infinity over infinity.
    queue_row(mk_row(10'd600, 1'b1, ONE, ONE, 11'd1024, 1'b0));
    queue_row(mk_row(10'd599, 1'b1, smps_pkg::DBL_INF, ONE, 11'h7FF, 1'b0));
    queue_row(mk_row(10'd598, 1'b1, TWO, TWO, 11'd1023, 1'b1));
    // A NaN first candidate is never displaced and is not singular.
    queue_row(mk_row(10'd30, 1'b1, smps_pkg::DBL_QNAN, ONE, 11'd0, 1'b0));
    queue_row(mk_row(10'd29, 1'b1, TWO, TWO, 11'd0, 1'b1));
    // Zero pivot magnitude against a zero tolerance, then a lone pivot row.
    queue_row(mk_row(10'd2, 1'b1, 64'h8000_0000_0000_0000, ONE, 11'd3, 1'b1));
    queue_row(mk_row(10'd1023, 1'b1, '1, 64'h7FEF_FFFF_FFFF_FFFF, 11'd0, 1'b1));
    // A subnormal magnitude with a zero count keeps its value.
    queue_row(mk_row(10'd12, 1'b1, 64'h0000_0000_0000_0003, ONE, 11'd0, 1'b0));
    queue_row(mk_row(10'd11, 1'b1, 64'h0000_0000_0000_0002, ONE, 11'd0, 1'b1));
    drain_block();

    write_tolerance(ONE);
    queue_row(mk_row(10'd1, 1'b1, HALF, ONE, 11'd0, 1'b1));
    queue_row(mk_row(10'd1, 1'b1, TWO, ONE, 11'd0, 1'b1));
    random_phase(150, 11, 53);

    write_tolerance('1);
    random_phase(150, 53, 11);

    write_tolerance(smps_pkg::DBL_INF);
    random_phase(150, 0, 0);

    write_tolerance({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF | HALF);
    random_phase(150, 0, 0);

    if (mismatches == 0) begin
      $display("sparse_markowitz_pivot_select_top_tb: PASS");
    end else begin
      $display("sparse_markowitz_pivot_select_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/smps_pkg.sv
hdl/smps_crit_pipe.sv
hdl/sparse_markowitz_pivot_select_top.sv
dv/sparse_markowitz_pivot_select_top_tb.sv
